[rtl/core/fcrc_pkg.sv]
// fcrc_pkg: constants, register codes and the byte-wise crc-32 update
// for the file crc checker; no dependencies
package fcrc_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CRC_FIELD_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CRC     = 2'd1;

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

[rtl/core/file_crc32_with_field_skip.sv]
// file_crc32_with_field_skip: streaming reflected crc-32 over a file with a
// zeroed four-byte checksum window and compare against an expected value
// depends on fcrc_pkg
//
//  channel | signals                                   | request moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, data_byte, last_byte  | one file byte
//  out     | out_valid, out_ready, crc_value, crc_match| final crc of one file
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// one byte per cycle sustained unless a last byte waits on a full result: a
// request goes into the input stage, from there its byte is folded into the running
// crc by the eight-step unrolled xor network and, on the last byte, the result register is loaded
// reset (arst_n low) clears the running crc to all ones, position to zero,
// both registers to zero and empties input stage and result register
// a finished result waiting in the result register stalls only the next last
// byte; ordinary bytes keep flowing while out_ready is low
// cfg_ready is always high; writes take effect from the next byte hashed
module file_crc32_with_field_skip
	import fcrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// byte stream
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	// result
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          crc_value,
	output logic                 crc_match,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// configuration registers
	logic [15:0] crc_field_offset_q;
	logic [31:0] expected_crc_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// running state
	logic [31:0] crc_q;
	logic [31:0] pos_q;

	// result register
	logic        out_valid_q;
	logic [31:0] crc_value_q;
	logic        crc_match_q;

	logic        out_free;
	logic        go_s1;
	logic        in_win;
	logic [16:0] win_end;
	logic [7:0]  hashed_byte;
	logic [31:0] crc_next;
	logic [31:0] final_crc;

	assign cfg_ready = 1'b1;

	// result register can take a new value when empty or draining this cycle
	assign out_free = !out_valid_q || out_ready;
	// the staged byte proceeds unless it is a last byte blocked by a full result
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || go_s1;

	// checksum window [offset, offset+4), end never wraps in 17 bits
	assign win_end     = {1'b0, crc_field_offset_q} + 17'd4;
	assign in_win      = (pos_q >= {16'd0, crc_field_offset_q}) && (pos_q < {15'd0, win_end});
	assign hashed_byte = in_win ? 8'd0 : byte_s1;
	assign crc_next    = crc_byte(crc_q, hashed_byte);
	assign final_crc   = crc_next ^ CRC_ONES;

	// register writes, out-of-range indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_field_offset_q <= '0;
			expected_crc_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CRC_FIELD_OFFSET: crc_field_offset_q <= cfg_data[15:0];
				REG_EXPECTED_CRC:     expected_crc_q     <= cfg_data;
				default:              ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// running crc and saturating position, restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ONES;
			pos_q <= '0;
		end else if (go_s1) begin
			if (last_s1) begin
				crc_q <= CRC_ONES;
				pos_q <= '0;
			end else begin
				crc_q <= crc_next;
				if (pos_q != CRC_ONES) begin
					pos_q <= pos_q + 32'd1;
				end
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			crc_value_q <= final_crc;
			crc_match_q <= (final_crc == expected_crc_q);
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;
	assign crc_match = crc_match_q;

endmodule

[rtl/core/fcrc_checker.sv]
// fcrc_checker: port-level checks for file_crc32_with_field_skip and its bind
// depends on fcrc_pkg
module fcrc_checker
	import fcrc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [31:0]          crc_value,
	input logic                 crc_match,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	// copy of the expected value as written through the port
	logic [31:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index == REG_EXPECTED_CRC)) begin
			exp_q <= cfg_data;
		end
	end

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crc_value) && $stable(crc_match))
		else $error("result changed while stalled");

	// match flag agrees with the last written expected value
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (crc_match == (crc_value == exp_q)))
		else $error("crc_match disagrees with crc_value");

	// input backpressure only comes from a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a stalled result");

	// no result during reset
	a_reset_out: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// config port never pushes back
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg_ready low");

endmodule

bind file_crc32_with_field_skip fcrc_checker u_fcrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.crc_value (crc_value),
	.crc_match (crc_match),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
